FILE: rtl/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// shared types and constants for the modular exponentiation block
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam logic [31:0] ModulusReset = 32'd1000000007;
  localparam int unsigned CfgModulusIdx = 0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_BIT,
    ST_MUL,
    ST_SQR,
    ST_DONE
  } mexp_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture item, start base reduction
    logic start_mul;  // acc * pw
    logic start_sqr;  // pw * pw
    logic shift_exp;  // next exponent bit
  } mexp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic busy;       // modular reducer working
    logic exp_bit;    // current exponent bit
    logic last_bit;   // current bit is the last one
  } mexp_sts_t;

endpackage

FILE: rtl/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// modular_exponentiation
// base^exponent mod modulus by right-to-left square and multiply
// ----------------------------------------------------------------------------
// One word is worked at a time. After acceptance the base is reduced, then
// each of the EXPONENT_WIDTH exponent bits takes a square and, for a set
// bit, a multiply; every reduction runs in one shift-subtract reducer at one
// bit per cycle. The result is held until taken, and the input is ready
// again in the cycle after that.
module modular_exponentiation #(
  parameter int unsigned OPERAND_WIDTH  = 32,
  parameter int unsigned EXPONENT_WIDTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // base_value[31:0], exponent[95:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // power_result[31:0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mexp_pkg::*;

  logic [OPERAND_WIDTH-1:0] modulus_q;
  logic [OPERAND_WIDTH-1:0] result;
  mexp_cmd_t                cmd;
  mexp_sts_t                sts;

  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) modulus_q <= ModulusReset[OPERAND_WIDTH-1:0];
    else if (psel && penable && pwrite && paddr == 3'(CfgModulusIdx * 4))
      modulus_q <= pwdata[OPERAND_WIDTH-1:0];
  end
  assign prdata = (paddr == 3'(CfgModulusIdx * 4)) ? 32'(modulus_q) : '0;

  mexp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_fire_i   (s_axis_tvalid && s_axis_tready),
    .out_fire_i  (m_axis_tvalid && m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid)
  );

  mexp_datapath #(
    .OperandWidth  (OPERAND_WIDTH),
    .ExponentWidth (EXPONENT_WIDTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .modulus_i (modulus_q),
    .base_i    (s_axis_tdata[OPERAND_WIDTH-1:0]),
    .exp_i     (s_axis_tdata[32 +: EXPONENT_WIDTH]),
    .result_o  (result)
  );

  assign m_axis_tdata = 32'(result);

endmodule

FILE: rtl/mexp_datapath.sv
// ----------------------------------------------------------------------------
// mexp_datapath
// operand registers, multipliers and a shift-subtract reducer
// ----------------------------------------------------------------------------
module mexp_datapath #(
  parameter int unsigned OperandWidth  = 32,
  parameter int unsigned ExponentWidth = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mexp_pkg::mexp_cmd_t               cmd_i,
  output mexp_pkg::mexp_sts_t               sts_o,
  input  logic [OperandWidth-1:0]           modulus_i,
  input  logic [OperandWidth-1:0]           base_i,
  input  logic [ExponentWidth-1:0]          exp_i,
  output logic [OperandWidth-1:0]           result_o
);
  import mexp_pkg::*;

  localparam int unsigned W  = OperandWidth;
  localparam int unsigned PW = 2 * OperandWidth;
  localparam int unsigned CW = $clog2(PW + 1);
  localparam int unsigned EW = $clog2(ExponentWidth);

  logic [W-1:0]             acc_q, acc_d, pw_q, pw_d;
  logic [ExponentWidth-1:0] exp_q, exp_d;
  logic [EW-1:0]            bit_q, bit_d;
  logic [PW-1:0]            num_q, num_d;   // dividend bits still to shift in
  logic [W:0]               rem_q, rem_d;   // partial remainder
  logic [CW-1:0]            cnt_q, cnt_d;
  logic                     busy_q, busy_d;
  logic                     dst_q, dst_d;   // 1: result to acc, 0: to pw
  logic [W:0]               trial;
  logic [W:0]               shifted;

  always_comb begin
    shifted = {rem_q[W-1:0], num_q[PW-1]};
    trial   = shifted - {1'b0, modulus_i};
  end

  always_comb begin
    acc_d  = acc_q;
    pw_d   = pw_q;
    exp_d  = exp_q;
    bit_d  = bit_q;
    num_d  = num_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    dst_d  = dst_q;
    if (cmd_i.load) begin
      exp_d  = exp_i;
      bit_d  = '0;
      // acc starts as 1 mod m; m==1 or 0 gives 0
      acc_d  = (modulus_i > W'(1)) ? W'(1) : '0;
      num_d  = {{W{1'b0}}, base_i};
      rem_d  = '0;
      cnt_d  = CW'(PW);
      busy_d = 1'b1;
      dst_d  = 1'b0;
    end else if (cmd_i.start_mul || cmd_i.start_sqr) begin
      num_d  = cmd_i.start_mul ? PW'(acc_q) * PW'(pw_q) : PW'(pw_q) * PW'(pw_q);
      rem_d  = '0;
      cnt_d  = CW'(PW);
      busy_d = 1'b1;
      dst_d  = cmd_i.start_mul;
    end else if (busy_q) begin
      num_d = {num_q[PW-2:0], 1'b0};
      if (shifted >= {1'b0, modulus_i}) rem_d = trial;
      else rem_d = shifted;
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        if (modulus_i == '0) begin
          if (dst_q) acc_d = '0;
          else pw_d = '0;
        end else if (dst_q) begin
          acc_d = (shifted >= {1'b0, modulus_i}) ? trial[W-1:0] : shifted[W-1:0];
        end else begin
          pw_d = (shifted >= {1'b0, modulus_i}) ? trial[W-1:0] : shifted[W-1:0];
        end
      end
    end
    if (cmd_i.shift_exp) begin
      exp_d = exp_q >> 1;
      bit_d = bit_q + EW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    pw_q  <= pw_d;
    exp_q <= exp_d;
    bit_q <= bit_d;
    num_q <= num_d;
    rem_q <= rem_d;
    dst_q <= dst_d;
  end

  assign sts_o.busy     = busy_q;
  assign sts_o.exp_bit  = exp_q[0];
  assign sts_o.last_bit = (bit_q == EW'(ExponentWidth - 1));
  assign result_o       = acc_q;

endmodule

FILE: rtl/mexp_ctrl.sv
// ----------------------------------------------------------------------------
// mexp_ctrl
// sequencer for square and multiply over the exponent bits
// ----------------------------------------------------------------------------
module mexp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_fire_i,
  input  logic                out_fire_i,
  input  mexp_pkg::mexp_sts_t sts_i,
  output mexp_pkg::mexp_cmd_t cmd_o,
  output logic                in_ready_o,
  output logic                out_valid_o
);
  import mexp_pkg::*;

  mexp_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_fire_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (!sts_i.busy) state_d = ST_BIT;
      end
      ST_BIT: begin
        if (sts_i.exp_bit) begin
          cmd_o.start_mul = 1'b1;
          state_d         = ST_MUL;
        end else begin
          cmd_o.start_sqr = 1'b1;
          state_d         = ST_SQR;
        end
      end
      ST_MUL: begin
        if (!sts_i.busy) begin
          cmd_o.start_sqr = 1'b1;
          state_d         = ST_SQR;
        end
      end
      ST_SQR: begin
        if (!sts_i.busy) begin
          cmd_o.shift_exp = 1'b1;
          state_d         = sts_i.last_bit ? ST_DONE : ST_BIT;
        end
      end
      ST_DONE: begin
        out_valid_o = 1'b1;
        if (out_fire_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

FILE: rtl/mexp_checker.sv
// ----------------------------------------------------------------------------
// mexp_checker
// port-level checks for the modular exponentiation block
// ----------------------------------------------------------------------------
module mexp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);
  // one word in flight: no input taken while a result waits
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");

  // a result is never followed straight by another
  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid) else $error("extra result");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready && !m_axis_tvalid)
    else $error("not busy after accept");
endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives base/exponent words through the exponentiation block under several
// modulus settings and idle patterns, and checks every power against a
// square-and-multiply predictor kept in step with the modulus register
// ----------------------------------------------------------------------------
module testbench;
  import mexp_pkg::*;

  localparam int unsigned LongHold = 30000;
  localparam longint unsigned CycleLimit = 64'd40000000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata;   // base_value[31:0], exponent[95:32]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // power_result[31:0]
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic [31:0] modulus_q;
  logic [31:0] power_queue[$];
  int unsigned error_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_recv;
  longint unsigned cycle_count;

  modular_exponentiation u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [31:0] power_mod(logic [31:0] base_value, logic [63:0] exponent,
                                            logic [31:0] modulus);
    logic [63:0] acc;
    logic [63:0] pw;
    if (modulus == 0) return '0;
    pw  = 64'(base_value) % 64'(modulus);
    acc = 64'd1 % 64'(modulus);
    for (int i = 0; i < 64; i++) begin
      if (exponent[i]) acc = (acc * pw) % 64'(modulus);
      pw = (pw * pw) % 64'(modulus);
    end
    return acc[31:0];
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch: %s got %0d want %0d", what, got, want);
    error_count++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (power_queue.size() == 0) begin
        report("unexpected word", m_axis_tdata, '0);
      end else begin
        logic [31:0] want;
        want = power_queue.pop_front();
        if (m_axis_tdata !== want) report("power_result", m_axis_tdata, want);
      end
    end
  end

  // receiver ready pattern
  always @(negedge clk_i) begin
    if (!rst_ni || hold_recv) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout");
      $display("testbench NOT OK");
      $finish;
    end
  end

  // valid stays high after acceptance until the next word or the next drain
  task automatic send_word(logic [31:0] base_value, logic [63:0] exponent);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {exponent, base_value};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    power_queue.insert(power_queue.size(), power_mod(base_value, exponent, modulus_q));
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (power_queue.size() != 0) @(posedge clk_i);
    // let the block settle back to idle
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(int unsigned idx, logic [31:0] value);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'(4 * idx); pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (idx == CfgModulusIdx) modulus_q = value;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic check_readback();
    psel <= 1'b1; pwrite <= 1'b0; paddr <= 3'(4 * CfgModulusIdx);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== modulus_q) report("modulus readback", prdata, modulus_q);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0;
  endtask

  function automatic logic [63:0] rand_exponent();
    logic [63:0] e;
    e = {$urandom(), $urandom()};
    // mostly short exponents to keep the run quick
    case ($urandom_range(3))
      0: e = e & 64'hff;
      1: e = e & 64'hffff;
      2: e = e & 64'hffff_ffff;
      default: ;
    endcase
    return e;
  endfunction

  task automatic test_directed();
    check_readback();
    send_word(32'd2, 64'd0);
    send_word(32'hffff_ffff, 64'hffff_ffff_ffff_ffff);
    send_word(32'd0, 64'd0);
    send_word(32'd0, 64'd5);
    send_word(32'd1000000007, 64'd3);
    send_word(32'd3, 64'h8000_0000_0000_0000);
    send_word(32'hffff_ffff, 64'd1);
    send_word(32'd12345, 64'd1000000006);
    drain();
    write_reg(CfgModulusIdx, 32'd1);
    check_readback();
    send_word(32'd7, 64'd0);
    send_word(32'hffff_ffff, 64'hffff_ffff_ffff_ffff);
    drain();
    write_reg(CfgModulusIdx, 32'hffff_ffff);
    send_word(32'hffff_fffe, 64'hffff_ffff_ffff_ffff);
    send_word(32'hffff_ffff, 64'd2);
    send_word(32'd0, 64'd0);
    drain();
    write_reg(CfgModulusIdx, 32'd0);
    send_word(32'd5, 64'd3);
    send_word(32'd0, 64'd0);
    drain();
    write_reg(CfgModulusIdx, 32'd2);
    send_word(32'd3, 64'd9);
    send_word(32'd4, 64'd0);
    drain();
  endtask

  task automatic test_random(int unsigned n, int unsigned idle, int unsigned stall);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) send_word($urandom(), rand_exponent());
    drain();
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_recv = 1'b1;
    fork
      begin
        repeat (LongHold) @(posedge clk_i);
        hold_recv = 1'b0;
      end
      for (int i = 0; i < 6; i++) send_word($urandom(), rand_exponent() & 64'hff);
    join
    drain();
    // sender waits for everything before going on
    send_word($urandom(), rand_exponent());
    drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0; m_axis_tready = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    error_count = 0; send_idle_pct = 0; recv_stall_pct = 0; hold_recv = 1'b0;
    cycle_count = 0;
    modulus_q = ModulusReset;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    write_reg(CfgModulusIdx, ModulusReset);
    test_random(26, 0, 0);
    write_reg(CfgModulusIdx, $urandom() | 32'h8000_0000);
    test_random(26, 51, 0);
    write_reg(CfgModulusIdx, $urandom_range(65535, 2));
    test_random(26, 0, 51);
    write_reg(CfgModulusIdx, $urandom());
    test_random(26, 11, 11);
    test_backpressure();

    if (error_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

FILE: modular_exponentiation.f
rtl/mexp_pkg.sv
rtl/mexp_datapath.sv
rtl/mexp_ctrl.sv
rtl/modular_exponentiation.sv
rtl/mexp_checker.sv
test/testbench.sv
